/* rtl/dma_contiguous_run_mapper_defines.svh */
// Assertion macros of the run mapper checker
`ifndef DMA_CONTIGUOUS_RUN_MAPPER_DEFINES_SVH
`define DMA_CONTIGUOUS_RUN_MAPPER_DEFINES_SVH

// check at every rising edge outside of reset
`define DCRM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// check at every rising edge, reset included
`define DCRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dcrm_pkg.sv */
// Types and constants of the contiguous run mapper
`timescale 1ns / 1ps

package dcrm_pkg;

	localparam int FRAME_W = 20;
	localparam int LIM_W   = 20;
	localparam int NPG_W   = 9;
	localparam int PIDX_W  = 8;
	localparam int STEP_W  = 9;
	localparam int PTR_W   = 10;
	localparam int RUN_W   = 21;
	localparam int CNT_W   = 13;
	localparam int LEN_W   = 19;

	localparam logic [11:0]      PAGE_MASK  = 12'hFFF;
	localparam logic [12:0]      PAGE_BYTES = 13'h1000;
	localparam logic [LEN_W-1:0] LEN_MAX    = 19'h7FFFF;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_MAP  = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
	localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

	typedef struct packed {
		logic        func;
		logic [5:0]  page_index;
		logic [19:0] page_frame;
		logic [31:0] current_va;
		logic [31:0] start_va;
		logic [31:0] system_va;
		logic [11:0] byte_offset;
		logic [18:0] byte_count;
		logic [31:0] max_length;
	} req_t;

	typedef struct packed {
		logic [31:0] phys_addr;
		logic [18:0] run_length;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic offs;
		logic setup;
		logic ptr_inc;
		logic base;
		logic walk;
		logic result;
	} cmd_t;

	typedef struct packed {
		logic outside;
		logic too_big;
		logic in_range;
		logic walk_stop;
	} sts_t;

endpackage

/* rtl/dcrm_chan_if.sv */
// Valid/ready channel carrying one payload per transfer
`timescale 1ns / 1ps

interface dcrm_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/dma_contiguous_run_mapper.sv */
// Top level of the contiguous run mapper
// A load transfer writes one page frame number into the page store if its index is below
// MAX_PAGES. A map transfer picks the base that places the address inside the buffer, then
// walks the page store one frame per cycle through its single read port while the frames
// stay consecutive and the length limits are not reached; it skips the walk when the address
// is outside, the buffer is too large or the start lies past the buffer's last page, and
// otherwise walks at most MAX_PAGES - 1 further contiguous pages. A finished result waits in
// the output register while the next item is taken; a further result holds in its result
// state until the waiting one is transferred.
`timescale 1ns / 1ps

module dma_contiguous_run_mapper
	import dcrm_pkg::*;
#(
	parameter int MAX_PAGES = 64
) (
	input logic          clk,
	input logic          arst_n,
	dcrm_chan_if.sink    req,
	dcrm_chan_if.source  rsp
);

	cmd_t cmd;
	sts_t sts;
	req_t req_data;
	rsp_t rsp_data;
	logic req_ready;
	logic rsp_valid;

	assign req_data  = req.data;
	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

	dcrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req_data.func),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dcrm_datapath #(
		.MAX_PAGES (MAX_PAGES)
	) u_datapath (
		.clk      (clk),
		.req_data (req_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

endmodule

/* rtl/dcrm_ctrl.sv */
// Sequencer of the run mapper: handshakes, walk control, result slot
`timescale 1ns / 1ps

module dcrm_ctrl
	import dcrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_func,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFFS,
		ST_SETUP,
		ST_FETCH,
		ST_BASE,
		ST_WALK,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   accept;
	logic   slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load    = accept && (req_func == FUNC_LOAD);
				cmd.capture = accept && (req_func == FUNC_MAP);
			end
			ST_OFFS:   cmd.offs = 1'b1;
			ST_SETUP:  cmd.setup = 1'b1;
			ST_FETCH:  cmd.ptr_inc = 1'b1;
			ST_BASE: begin
				cmd.base    = 1'b1;
				cmd.ptr_inc = 1'b1;
			end
			ST_WALK: begin
				cmd.walk    = !sts.walk_stop;
				cmd.ptr_inc = !sts.walk_stop;
			end
			ST_RESULT: cmd.result = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.result || (valid_q && !rsp_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_OFFS;
					end
				end
				ST_OFFS: state_q <= ST_SETUP;
				ST_SETUP: begin
					if (sts.outside || sts.too_big || !sts.in_range) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_BASE;
				ST_BASE:  state_q <= ST_WALK;
				ST_WALK: begin
					if (sts.walk_stop) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/dcrm_datapath.sv */
// Page store, offset selection, run walk and result register
`timescale 1ns / 1ps

module dcrm_datapath
	import dcrm_pkg::*;
#(
	parameter int MAX_PAGES = 64
) (
	input  logic clk,
	input  req_t req_data,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp_data
);

	localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(MAX_PAGES);

	logic [FRAME_W-1:0] frames_q [MAX_PAGES];
	logic [FRAME_W-1:0] rd_data_q;

	logic [31:0]        cva_q;
	logic [31:0]        sva_q;
	logic [31:0]        kva_q;
	logic [11:0]        boff_q;
	logic [18:0]        bcnt_q;
	logic [31:0]        maxlen_q;
	logic [LIM_W-1:0]   limit_q;
	logic [LIM_W-1:0]   offset_q;
	logic               outside_q;
	logic [NPG_W-1:0]   npages_q;
	logic [LIM_W-1:0]   total_q;
	logic [RUN_W-1:0]   run_q;
	logic [STEP_W-1:0]  step_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [FRAME_W-1:0] base_q;
	rsp_t               rsp_q;

	logic               wr_ok;
	logic [IDX_W-1:0]   wr_addr;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;

	logic [LIM_W-1:0]   limit_c;
	logic [31:0]        off_u;
	logic [31:0]        off_k;
	logic               fit_u;
	logic               fit_k;
	logic [LIM_W:0]     npg_sum;

	logic [PIDX_W-1:0]  idx;
	logic [STEP_W-1:0]  cur;
	logic [RUN_W-1:0]   frame_sum;
	logic [RUN_W-1:0]   len_a;
	logic [RUN_W-1:0]   len_b;
	logic [LEN_W-1:0]   len_c;

	assign wr_ok   = CNT_W'(req_data.page_index) < DEPTH;
	assign wr_addr = IDX_W'(req_data.page_index);
	assign rd_en   = CNT_W'(ptr_q) < DEPTH;
	assign rd_addr = IDX_W'(ptr_q);

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			frames_q[wr_addr] <= req_data.page_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= frames_q[rd_addr];
		end
	end

	assign limit_c = LIM_W'(boff_q) + LIM_W'(bcnt_q);
	assign off_u   = cva_q - sva_q;
	assign off_k   = cva_q - kva_q;
	assign fit_u   = off_u <= 32'(limit_c);
	assign fit_k   = (kva_q != '0) && (off_k <= 32'(limit_c));
	assign npg_sum = (LIM_W+1)'(limit_c) + (LIM_W+1)'(PAGE_MASK);

	assign idx       = offset_q[LIM_W-1:12];
	assign cur       = STEP_W'(idx) + step_q;
	assign frame_sum = RUN_W'(base_q) + RUN_W'(step_q);

	always_comb begin
		sts.outside   = outside_q;
		sts.too_big   = CNT_W'(npages_q) > DEPTH;
		sts.in_range  = NPG_W'(idx) < npages_q;
		sts.walk_stop = (32'(run_q) >= maxlen_q) || (run_q >= RUN_W'(total_q))
			|| (NPG_W'(cur) >= npages_q) || (RUN_W'(rd_data_q) != frame_sum);
	end

	always_comb begin
		len_a = (32'(run_q) > maxlen_q) ? maxlen_q[RUN_W-1:0] : run_q;
		len_b = (len_a > RUN_W'(total_q)) ? RUN_W'(total_q) : len_a;
		len_c = (len_b > RUN_W'(LEN_MAX)) ? LEN_MAX : len_b[LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cva_q    <= req_data.current_va;
			sva_q    <= req_data.start_va;
			kva_q    <= req_data.system_va;
			boff_q   <= req_data.byte_offset;
			bcnt_q   <= req_data.byte_count;
			maxlen_q <= req_data.max_length;
		end
		if (cmd.offs) begin
			limit_q   <= limit_c;
			offset_q  <= fit_u ? off_u[LIM_W-1:0] : off_k[LIM_W-1:0];
			outside_q <= !fit_u && !fit_k;
			npages_q  <= npg_sum[LIM_W:12];
		end
		if (cmd.setup) begin
			total_q <= limit_q - offset_q;
			run_q   <= RUN_W'(PAGE_BYTES - 13'(offset_q[11:0]));
			step_q  <= STEP_W'(1);
			ptr_q   <= PTR_W'(idx);
		end
		if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
		if (cmd.base) begin
			base_q <= rd_data_q;
		end
		if (cmd.walk) begin
			run_q  <= run_q + RUN_W'(PAGE_BYTES);
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.result) begin
			if (outside_q) begin
				rsp_q.phys_addr  <= '0;
				rsp_q.run_length <= '0;
				rsp_q.status     <= STATUS_OUTSIDE;
			end else if (sts.too_big) begin
				rsp_q.phys_addr  <= '0;
				rsp_q.run_length <= '0;
				rsp_q.status     <= STATUS_TOO_BIG;
			end else begin
				rsp_q.phys_addr  <= sts.in_range ? {base_q, offset_q[11:0]} : '0;
				rsp_q.run_length <= len_c;
				rsp_q.status     <= STATUS_OK;
			end
		end
	end

	assign rsp_data = rsp_q;

endmodule

/* rtl/dcrm_checker.sv */
// Port checker of the run mapper and its bind
`timescale 1ns / 1ps
`include "dma_contiguous_run_mapper_defines.svh"

module dcrm_checker
	import dcrm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_func,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_phys_addr,
	input logic [18:0] rsp_run_length,
	input logic [1:0]  rsp_status
);

	`DCRM_ASSERT_ALWAYS(a_reset_no_rsp, clk, !arst_n |-> !rsp_valid, "result valid in reset")
	`DCRM_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phys_addr) && $stable(rsp_run_length) && $stable(rsp_status), "stalled transfer changed")
	`DCRM_ASSERT(a_map_busy, clk, arst_n, req_valid && req_ready && req_func == FUNC_MAP |=> !req_ready, "map transfer not followed by busy")
	`DCRM_ASSERT(a_load_silent, clk, arst_n, req_valid && req_ready && req_func == FUNC_LOAD && !rsp_valid |=> !rsp_valid, "load transfer produced a result")
	`DCRM_ASSERT(a_err_zero, clk, arst_n, rsp_valid && rsp_status != STATUS_OK |-> rsp_phys_addr == '0 && rsp_run_length == '0, "error result not zero")

endmodule

bind dma_contiguous_run_mapper dcrm_checker u_dcrm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_func       (req.data.func),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_phys_addr  (rsp.data.phys_addr),
	.rsp_run_length (rsp.data.run_length),
	.rsp_status     (rsp.data.status)
);
